// ----- rtl/core/hspc_pkg.sv -----
package hspc_pkg;

    // register map of the configuration port
    localparam int CfgIndexWidth = 2;
    localparam logic [CfgIndexWidth-1:0] REG_MEASURE_PERIOD = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_READY_DELAY    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_WAIT_TIMEOUT   = 2'd2;

    localparam logic [15:0] MEASURE_PERIOD_RST = 16'd1000;
    localparam logic [15:0] READY_DELAY_RST    = 16'd80;
    localparam logic [15:0] WAIT_TIMEOUT_RST   = 16'd200;

    localparam int BusyBit  = 7;
    localparam int FracBits = 20;

    localparam logic [9:0]         HUMI_SCALE  = 10'd1000;
    localparam logic [10:0]        TEMP_SCALE  = 11'd2000;
    localparam logic signed [31:0] TEMP_OFFSET = 32'sd524288000;  // 500 * 2^20

    typedef struct packed {
        logic [31:0] now_ms;
        logic        status_read_ok;
        logic [7:0]  status_byte;
        logic        frame_read_ok;
        logic [47:0] frame_bytes;
    } item_t;

    typedef struct packed {
        logic [15:0] measure_period_ms;
        logic [15:0] ready_delay_ms;
        logic [15:0] wait_timeout_ms;
    } cfg_t;

    // decoded sensor answer plus converted values
    typedef struct packed {
        logic        sensor_ready;
        logic        frame_good;
        logic [11:0] temp_tenths;
        logic [9:0]  humi_tenths;
    } conv_t;

endpackage

// ----- rtl/core/humidity_sensor_poll_convert.sv -----
// An input beat reaches its result beat through the input register and then the result register.
// Throughput: one beat per cycle unless m_ready holds back a valid result; phase and start tick
//   update in the result stage, so back-to-back beats see the state left by the previous one.
// Reset (aresetn low at a clock edge): pipeline empty, phase idle, start tick and stored
//   readings zero, configuration at 1000 / 80 / 200 ms.
module humidity_sensor_poll_convert (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [hspc_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [15:0]                           cfg_wdata,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [31:0]                           s_now_ms,
    input  logic                                  s_status_read_ok,
    input  logic [7:0]                            s_status_byte,
    input  logic                                  s_frame_read_ok,
    input  logic [47:0]                           s_frame_bytes,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_send_start,
    output logic                                  m_new_reading,
    output logic                                  m_timed_out,
    output logic                                  m_waiting,
    output logic signed [11:0]                    m_temp_tenths,
    output logic [9:0]                            m_humi_tenths
);

    hspc_pkg::cfg_t  cfg_reg;
    hspc_pkg::item_t s_item;
    hspc_pkg::item_t item;
    hspc_pkg::conv_t conv;
    logic            item_valid;
    logic            item_take;

    // Configuration registers; writes to an unmapped index are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.measure_period_ms <= hspc_pkg::MEASURE_PERIOD_RST;
            cfg_reg.ready_delay_ms    <= hspc_pkg::READY_DELAY_RST;
            cfg_reg.wait_timeout_ms   <= hspc_pkg::WAIT_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hspc_pkg::REG_MEASURE_PERIOD: cfg_reg.measure_period_ms <= cfg_wdata;
                hspc_pkg::REG_READY_DELAY:    cfg_reg.ready_delay_ms    <= cfg_wdata;
                hspc_pkg::REG_WAIT_TIMEOUT:   cfg_reg.wait_timeout_ms   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_item.now_ms         = s_now_ms;
    assign s_item.status_read_ok = s_status_read_ok;
    assign s_item.status_byte    = s_status_byte;
    assign s_item.frame_read_ok  = s_frame_read_ok;
    assign s_item.frame_bytes    = s_frame_bytes;

    // Stage 1: capture the beat.
    hspc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Status decode and fixed-point scaling (one 20x10 and one 20x11 multiply).
    hspc_conv u_conv (
        .item (item),
        .conv (conv)
    );

    // Stage 2: phase/timer decisions, stored readings and result register.
    hspc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .now_ms        (item.now_ms),
        .conv          (conv),
        .item_take     (item_take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_send_start  (m_send_start),
        .m_new_reading (m_new_reading),
        .m_timed_out   (m_timed_out),
        .m_waiting     (m_waiting),
        .m_temp_tenths (m_temp_tenths),
        .m_humi_tenths (m_humi_tenths)
    );

endmodule

// ----- rtl/core/hspc_in_reg.sv -----
module hspc_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  hspc_pkg::item_t s_item,
    output logic           item_valid,
    output hspc_pkg::item_t item,
    input  logic           item_take
);

    logic            valid_reg;
    logic            valid_next;
    hspc_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/core/hspc_conv.sv -----
module hspc_conv (
    input  hspc_pkg::item_t item,
    output hspc_pkg::conv_t conv
);

    logic [19:0]        raw_h;
    logic [19:0]        raw_t;
    logic [29:0]        prod_h;
    logic [30:0]        prod_t;
    logic signed [31:0] num_t;
    logic [31:0]        mag_t;
    logic [11:0]        quo_t;

    assign raw_h  = item.frame_bytes[39:20];
    assign raw_t  = item.frame_bytes[19:0];
    assign prod_h = 30'(raw_h * hspc_pkg::HUMI_SCALE);
    assign prod_t = 31'(raw_t * hspc_pkg::TEMP_SCALE);

    // signed numerator, then divide by 2^20 rounding toward zero
    assign num_t = $signed({1'b0, prod_t}) - hspc_pkg::TEMP_OFFSET;
    assign mag_t = num_t[31] ? 32'(-num_t) : 32'(num_t);
    assign quo_t = mag_t[31:hspc_pkg::FracBits];

    assign conv.sensor_ready = item.status_read_ok && !item.status_byte[hspc_pkg::BusyBit];
    assign conv.frame_good   = item.frame_read_ok
                            && !item.frame_bytes[40 + hspc_pkg::BusyBit];
    assign conv.humi_tenths  = prod_h[29:hspc_pkg::FracBits];
    assign conv.temp_tenths  = num_t[31] ? 12'(-quo_t) : quo_t;

endmodule

// ----- rtl/core/hspc_ctrl.sv -----
module hspc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  hspc_pkg::cfg_t  cfg,
    input  logic            item_valid,
    input  logic [31:0]     now_ms,
    input  hspc_pkg::conv_t conv,
    output logic            item_take,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_send_start,
    output logic            m_new_reading,
    output logic            m_timed_out,
    output logic            m_waiting,
    output logic signed [11:0] m_temp_tenths,
    output logic [9:0]      m_humi_tenths
);

    logic        valid_reg,   valid_next;
    logic        phase_reg,   phase_next;
    logic [31:0] start_reg,   start_next;
    logic [11:0] temp_reg,    temp_next;
    logic [9:0]  humi_reg,    humi_next;
    logic        start_o_reg, start_o_next;
    logic        fresh_reg,   fresh_next;
    logic        expire_reg,  expire_next;
    logic [31:0] elapsed;
    logic        advance;

    assign advance   = !valid_reg || m_ready;
    assign item_take = advance;
    assign elapsed   = now_ms - start_reg;

    always_comb begin
        phase_next   = phase_reg;
        start_next   = start_reg;
        temp_next    = temp_reg;
        humi_next    = humi_reg;
        start_o_next = 1'b0;
        fresh_next   = 1'b0;
        expire_next  = 1'b0;
        valid_next   = advance ? item_valid : valid_reg;
        if (!(item_valid && advance)) begin
            start_o_next = start_o_reg;
            fresh_next   = fresh_reg;
            expire_next  = expire_reg;
        end else if (!phase_reg) begin
            if (elapsed >= {16'd0, cfg.measure_period_ms}) begin
                start_o_next = 1'b1;
                start_next   = now_ms;
                phase_next   = 1'b1;
            end
        end else if (elapsed >= {16'd0, cfg.ready_delay_ms}) begin
            if (conv.sensor_ready) begin
                if (conv.frame_good) begin
                    temp_next  = conv.temp_tenths;
                    humi_next  = conv.humi_tenths;
                    fresh_next = 1'b1;
                end
                phase_next = 1'b0;
            end else if (elapsed >= {16'd0, cfg.wait_timeout_ms}) begin
                expire_next = 1'b1;
                phase_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            phase_reg   <= 1'b0;
            start_reg   <= '0;
            temp_reg    <= '0;
            humi_reg    <= '0;
            start_o_reg <= 1'b0;
            fresh_reg   <= 1'b0;
            expire_reg  <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            phase_reg   <= phase_next;
            start_reg   <= start_next;
            temp_reg    <= temp_next;
            humi_reg    <= humi_next;
            start_o_reg <= start_o_next;
            fresh_reg   <= fresh_next;
            expire_reg  <= expire_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_send_start  = start_o_reg;
    assign m_new_reading = fresh_reg;
    assign m_timed_out   = expire_reg;
    assign m_waiting     = phase_reg;
    assign m_temp_tenths = temp_reg;
    assign m_humi_tenths = humi_reg;

`ifndef SYNTHESIS
    // a start always leaves the block waiting
    a_start_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_start |-> m_waiting)
        else $error("start issued but phase is idle");

    // ending a wait always returns to idle
    a_end_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_new_reading || m_timed_out) |-> !m_waiting)
        else $error("wait ended but phase still waiting");

    // at most one event per beat
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_send_start, m_new_reading, m_timed_out}) <= 1)
        else $error("more than one event in one beat");

    // stored humidity changes only on a fresh reading
    a_store_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !m_new_reading |-> $stable(m_humi_tenths))
        else $error("humidity changed without a new reading");
`endif

endmodule
